/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

/* design/dtpc_pkg.sv */
// ---------------------------------------------------------------------------
// Depth to point cloud package
// Field widths, register indexes, reset values and control types.
// ---------------------------------------------------------------------------
`default_nettype none

package dtpc_pkg;

  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COORD_W    = 40;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned FOCAL_W    = 24;
  localparam int unsigned CENTER_W   = 16;
  localparam int unsigned FRAC_DROP  = 20;
  localparam int unsigned SPLIT_W    = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;

  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [FOCAL_W-1:0]  RST_INV_FOCAL    = 24'd31957;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic load;
  } dtpc_cmd_t;

endpackage

`default_nettype wire

/* design/dtpc_if.sv */
// ---------------------------------------------------------------------------
// Depth to point cloud channels
// Valid/ready channels for depth pixels in and points out.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtpc_pix_if
  import dtpc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DEPTH_W-1:0] depth;

  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface dtpc_pt_if
  import dtpc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [DEPTH_W-1:0] z_coord;
  logic                      point_valid;
  logic                      frame_last;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  output point_valid, output frame_last, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  input point_valid, input frame_last, output ready);
endinterface

`default_nettype wire

/* design/dtpc_ctrl.sv */
// ---------------------------------------------------------------------------
// Depth to point cloud controller
// Sequences capture, two multiply steps and the output load for one pixel.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dtpc_ctrl
  import dtpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dtpc_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
    endcase
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_accept_starts_mul, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == ST_MUL1), "transfer in did not start the multiply sequence")
  `ASSERT_CLK(a_out_from_load, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_LOAD), "output became valid without a load")
  `ASSERT_CLK(a_stall_holds_load, clk_i, rst_ni, (state_q == ST_LOAD && out_valid_q && !out_ready_i) |=> (state_q == ST_LOAD), "result overwrote a point still waiting")
  `ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |-> (state_q == ST_IDLE && !out_valid_q), "controller not idle in reset")

endmodule

`default_nettype wire

/* design/dtpc_datapath.sv */
// ---------------------------------------------------------------------------
// Depth to point cloud datapath
// Configuration registers, raster counters, split multipliers and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dtpc_datapath
  import dtpc_pkg::*;
#(
  parameter int unsigned MAX_DIM_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dtpc_cmd_t                    cmd_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [DEPTH_W-1:0]    depth_i,
  output logic signed [COORD_W-1:0]    x_coord_o,
  output logic signed [COORD_W-1:0]    y_coord_o,
  output logic signed [DEPTH_W-1:0]    z_coord_o,
  output logic                         point_valid_o,
  output logic                         frame_last_o
);

  localparam int unsigned CntW  = MAX_DIM_BITS;
  localparam int unsigned CmpW  = (CntW + 1 > DIM_W) ? CntW + 1 : DIM_W;
  localparam int unsigned OffW  = (CntW + 4 > CENTER_W) ? CntW + 4 : CENTER_W;
  localparam int unsigned DxW   = OffW + 1;
  localparam int unsigned P1W   = DxW + DEPTH_W;
  localparam int unsigned LoPW  = SPLIT_W + FOCAL_W;
  localparam int unsigned HiPW  = P1W - SPLIT_W + FOCAL_W + 1;
  localparam int unsigned SumW  = P1W + FOCAL_W + 1;
  localparam int unsigned FullW = (SumW > FRAC_DROP + COORD_W) ? SumW : FRAC_DROP + COORD_W;
  localparam logic [CmpW-1:0] DimLimit = CmpW'(1) << CntW;

  logic [DIM_W-1:0]    width_q, height_q;
  logic [FOCAL_W-1:0]  ifx_q, ify_q;
  logic [CENTER_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      ifx_q    <= RST_INV_FOCAL;
      ify_q    <= RST_INV_FOCAL;
      cx_q     <= RST_CENTER_X;
      cy_q     <= RST_CENTER_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_INV_FOCAL_X:  ifx_q    <= cfg_data_i[FOCAL_W-1:0];
        REG_INV_FOCAL_Y:  ify_q    <= cfg_data_i[FOCAL_W-1:0];
        REG_CENTER_X:     cx_q     <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y:     cy_q     <= cfg_data_i[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position counters and the last-in-row and last-in-frame tests.
  logic [CntW-1:0] col_q, row_q;
  logic [CmpW-1:0] col_nx, row_nx;
  logic            col_last, row_last;

  assign col_nx   = CmpW'(col_q) + CmpW'(1);
  assign row_nx   = CmpW'(row_q) + CmpW'(1);
  assign col_last = (col_nx >= CmpW'(width_q)) || (col_nx >= DimLimit);
  assign row_last = (row_nx >= CmpW'(height_q)) || (row_nx >= DimLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + CntW'(1);
      end else begin
        col_q <= col_q + CntW'(1);
      end
    end
  end

  logic signed [DEPTH_W-1:0] d_q;
  logic [CntW-1:0]           col_s_q, row_s_q;
  logic                      valid_s_q, last_s_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      d_q       <= depth_i;
      col_s_q   <= col_q;
      row_s_q   <= row_q;
      valid_s_q <= !depth_i[DEPTH_W-1];
      last_s_q  <= col_last && row_last;
    end
  end

  // First step: depth times the offset from the principal point.
  logic [OffW-1:0]        col_off, row_off, cx_ext, cy_ext;
  logic signed [DxW-1:0]  dx_d, dy_d;
  logic signed [P1W-1:0]  p1x_d, p1y_d, p1x_q, p1y_q;

  assign col_off = OffW'({col_s_q, 4'b0000});
  assign row_off = OffW'({row_s_q, 4'b0000});
  assign cx_ext  = OffW'(cx_q);
  assign cy_ext  = OffW'(cy_q);
  assign dx_d    = $signed({1'b0, col_off}) - $signed({1'b0, cx_ext});
  assign dy_d    = $signed({1'b0, cy_ext}) - $signed({1'b0, row_off});
  assign p1x_d   = P1W'(d_q) * P1W'(dx_d);
  assign p1y_d   = P1W'(d_q) * P1W'(dy_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1x_q <= p1x_d;
      p1y_q <= p1y_d;
    end
  end

  // Second step: the reciprocal focal length times the low and high halves.
  logic [LoPW-1:0]        lox_d, loy_d, lox_q, loy_q;
  logic signed [HiPW-1:0] hix_d, hiy_d, hix_q, hiy_q;

  assign lox_d = LoPW'(p1x_q[SPLIT_W-1:0]) * LoPW'(ifx_q);
  assign loy_d = LoPW'(p1y_q[SPLIT_W-1:0]) * LoPW'(ify_q);
  assign hix_d = HiPW'($signed(p1x_q[P1W-1:SPLIT_W])) * HiPW'($signed({1'b0, ifx_q}));
  assign hiy_d = HiPW'($signed(p1y_q[P1W-1:SPLIT_W])) * HiPW'($signed({1'b0, ify_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      lox_q <= lox_d;
      loy_q <= loy_d;
      hix_q <= hix_d;
      hiy_q <= hiy_d;
    end
  end

  // Recombine the halves; the fraction drop is a bit select of the full product.
  logic [FullW-1:0]          sum_x, sum_y;
  logic signed [COORD_W-1:0] x_d, y_d;
  logic signed [DEPTH_W-1:0] z_d;

  assign sum_x = ({{(FullW - HiPW){hix_q[HiPW-1]}}, hix_q} << SPLIT_W)
               + {{(FullW - LoPW){1'b0}}, lox_q};
  assign sum_y = ({{(FullW - HiPW){hiy_q[HiPW-1]}}, hiy_q} << SPLIT_W)
               + {{(FullW - LoPW){1'b0}}, loy_q};
  assign x_d   = valid_s_q ? $signed(sum_x[FRAC_DROP +: COORD_W]) : '0;
  assign y_d   = valid_s_q ? $signed(sum_y[FRAC_DROP +: COORD_W]) : '0;
  assign z_d   = valid_s_q ? -d_q : '0;

  logic signed [COORD_W-1:0] x_q, y_q;
  logic signed [DEPTH_W-1:0] z_q;
  logic                      pv_q, fl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      pv_q <= valid_s_q;
      fl_q <= last_s_q;
    end
  end

  assign x_coord_o     = x_q;
  assign y_coord_o     = y_q;
  assign z_coord_o     = z_q;
  assign point_valid_o = pv_q;
  assign frame_last_o  = fl_q;

  `ASSERT_CLK(a_frame_wrap, clk_i, rst_ni, (cmd_i.capture && col_last && row_last) |=> (col_q == '0 && row_q == '0), "counters did not wrap at the end of a frame")
  `ASSERT_CLK(a_invalid_zero, clk_i, rst_ni, (cmd_i.load && !valid_s_q) |=> (x_q == '0 && y_q == '0 && z_q == '0 && !pv_q), "invalid pixel gave a nonzero point")
  `ASSERT_CLK(a_valid_z_sign, clk_i, rst_ni, (cmd_i.load && valid_s_q) |=> (pv_q && (z_q[DEPTH_W-1] || z_q == '0)), "valid point has a positive z")

endmodule

`default_nettype wire

/* design/depth_to_point_cloud.sv */
// ---------------------------------------------------------------------------
// Depth to point cloud
// Back-projects raster-order depth pixels through a pinhole camera model.
// ---------------------------------------------------------------------------
// Depth pixels enter on the pix_i channel in raster order, one transfer per
// pixel, and each gives one point on the pt_o channel with x, y, z, a valid
// flag and a frame-last flag. Column and row counters track the position of
// the pixel and wrap at the configured image width and height, or at
// 2**MAX_DIM_BITS if that is smaller. The camera registers are written
// through the cfg_we_i, cfg_idx_i and cfg_data_i port; the user must write
// them only while no pixel is being processed; the block itself does not enforce it.
// A pixel passes a capture step, a multiply of the depth by the offset from
// the principal point, a multiply through a split 18-bit by 24-bit partial
// product unit, and a load into the output register. A new pixel is accepted
// only after the previous one has been loaded. Reset clears the counters,
// restores the default camera registers and clears the output valid flag.
// While the receiver stalls, the finished point waits in the output register;
// the next pixel is still accepted and computed, and it then waits in the
// load step until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module depth_to_point_cloud
  import dtpc_pkg::*;
#(
  parameter int unsigned MAX_DIM_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dtpc_pix_if.sink              pix_i,
  dtpc_pt_if.source             pt_o
);

  dtpc_cmd_t cmd;

  dtpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (pt_o.valid),
    .out_ready_i (pt_o.ready),
    .cmd_o       (cmd)
  );

  dtpc_datapath #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .depth_i       (pix_i.depth),
    .x_coord_o     (pt_o.x_coord),
    .y_coord_o     (pt_o.y_coord),
    .z_coord_o     (pt_o.z_coord),
    .point_valid_o (pt_o.point_valid),
    .frame_last_o  (pt_o.frame_last)
  );

endmodule

`default_nettype wire
